[rtl/core/swsd_pkg.sv]
// Shared types and constants for the moving standard deviation block.
// Holds field widths, controller states and the controller/datapath command
// and status structs. No dependencies.
package swsd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DEV_W    = 16;
  localparam int HELD_W   = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_MSTART,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic fetch;
    logic update;
    logic mul_start;
    logic mul_step;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ge2;
    logic iter_done;
  } status_t;

endpackage

[rtl/core/sliding_window_std_dev.sv]
// Moving population standard deviation over the last WINDOW signed Q1.15
// samples; one result word per input word. Each word passes through idle,
// fetch, update and start; then the shift-add multiplier runs one bit of the
// count per cycle, the square root one result bit per cycle and the divider
// one quotient bit per cycle, and finish hands the result over. Under two
// held samples the maths is skipped and the deviation reads zero.
// One word is in work at a time; a finished result sits in the output register
// while the next input word is taken, and a held-off output stalls the finish.
// Depends on swsd_pkg, swsd_ctrl, swsd_dp, swsd_ram.
module sliding_window_std_dev #(
  parameter int WINDOW = 50
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [swsd_pkg::IN_TDATA_W-1:0]  s_tdata,   // [15:0] sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [swsd_pkg::OUT_TDATA_W-1:0] m_tdata    // [15:0] deviation,
                                                      // [21:16] samples_held,
                                                      // [23:22] zero
);

  swsd_pkg::cmd_t    cmd;
  swsd_pkg::status_t status;
  logic [swsd_pkg::DEV_W-1:0]  deviation;
  logic [swsd_pkg::HELD_W-1:0] samples_held;

  swsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  swsd_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_in    (s_tdata[swsd_pkg::SAMPLE_W-1:0]),
    .deviation    (deviation),
    .samples_held (samples_held)
  );

  assign m_tdata = {2'b00, samples_held, deviation};

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("result loaded over a pending word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a word is in work");

  a_iter_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.iter_done)
    else $error("result loaded with an iteration still running");
`endif

endmodule

[rtl/core/swsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/swsd_ctrl.sv]
// Controller state machine for the moving standard deviation block.
// Sequences fetch, update, multiply, square root and divide; owns output valid.
// Depends on swsd_pkg.
module swsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output swsd_pkg::cmd_t   cmd,
  input  swsd_pkg::status_t status
);

  swsd_pkg::state_t state, state_next;
  logic out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swsd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      swsd_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = swsd_pkg::ST_FETCH;
        end
      end
      swsd_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = swsd_pkg::ST_UPDATE;
      end
      swsd_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = swsd_pkg::ST_MSTART;
      end
      swsd_pkg::ST_MSTART: begin
        // under two samples the deviation is forced to zero, skip the maths
        if (status.ge2) begin
          cmd.mul_start = 1'b1;
          state_next    = swsd_pkg::ST_MUL;
        end else begin
          state_next = swsd_pkg::ST_FINISH;
        end
      end
      swsd_pkg::ST_MUL: begin
        if (status.iter_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = swsd_pkg::ST_SQRT;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      swsd_pkg::ST_SQRT: begin
        if (status.iter_done) begin
          cmd.div_start = 1'b1;
          state_next    = swsd_pkg::ST_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      swsd_pkg::ST_DIV: begin
        if (status.iter_done) begin
          state_next = swsd_pkg::ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      swsd_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = swsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~m_tready);
  assign s_tready       = (state == swsd_pkg::ST_IDLE);
  assign m_tvalid       = out_valid;

endmodule

[rtl/core/swsd_dp.sv]
// Datapath for the moving standard deviation block: sample ring, running sums,
// shift-add multiplier, bitwise square root and restoring divider.
// Depends on swsd_pkg and swsd_ram.
module swsd_dp #(
  parameter int WINDOW = 50
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swsd_pkg::cmd_t                 cmd,
  output swsd_pkg::status_t              status,
  input  logic [swsd_pkg::SAMPLE_W-1:0]  sample_in,
  output logic [swsd_pkg::DEV_W-1:0]     deviation,
  output logic [swsd_pkg::HELD_W-1:0]    samples_held
);

  localparam int SW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int SUMW = swsd_pkg::SAMPLE_W + CW;
  localparam int MAGW = SUMW - 1;
  localparam int SQW  = 2 * swsd_pkg::SAMPLE_W - 2 + CW;
  localparam int PW   = SQW + CW;
  localparam int RW   = (PW + 1) / 2;
  localparam int IW   = $clog2(RW + 1);

  // ring and running state
  logic [SW-1:0]                       slot;
  logic [CW-1:0]                       count;
  logic signed [SUMW-1:0]              sum;
  logic [SQW-1:0]                      sqsum;
  logic signed [swsd_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [swsd_pkg::SAMPLE_W-1:0] old_q;
  logic signed [swsd_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [2*swsd_pkg::SAMPLE_W-2:0]     sq_new;
  logic [2*swsd_pkg::SAMPLE_W-2:0]     sq_old;
  logic signed [2*swsd_pkg::SAMPLE_W-1:0] sq_new_full;
  logic signed [2*swsd_pkg::SAMPLE_W-1:0] sq_old_full;
  logic                                full;

  // arithmetic
  logic [IW-1:0]       iter;
  logic [SUMW-1:0]     sum_abs;
  logic [MAGW-1:0]     mag;
  logic [PW-1:0]       mag_sq;
  logic [PW-1:0]       acc;
  logic [PW-1:0]       mcand;
  logic [CW-1:0]       mplier;
  logic [2*RW-1:0]     rad;
  logic [RW+1:0]       rem;
  logic [RW-1:0]       root;
  logic [RW+1:0]       rem_sh;
  logic [RW+1:0]       trial;
  logic [RW-1:0]       dvd;
  logic [CW:0]         drem;
  logic [CW:0]         dtrial;

  swsd_ram #(
    .WIDTH (swsd_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot),
    .wdata (sample_q),
    .re    (cmd.load_in),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  assign full        = (count == CW'(WINDOW));
  assign sq_new_full = sample_q * sample_q;
  assign sq_old_full = ram_rdata * ram_rdata;
  assign sum_abs     = sum[SUMW-1] ? (~sum + 1'b1) : sum;
  assign rem_sh      = {rem[RW-1:0], rad[2*RW-1 -: 2]};
  assign trial       = {root, 2'b01};
  assign dtrial      = {drem[CW-1:0], dvd[RW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
      sqsum <= '0;
      iter  <= '0;
    end else begin
      if (cmd.update) begin
        // evict the oldest word once the window is full
        sum   <= sum - (full ? SUMW'(old_q) : '0) + SUMW'(sample_q);
        sqsum <= sqsum - (full ? SQW'(sq_old) : '0) + SQW'(sq_new);
        slot  <= (slot == SW'(WINDOW - 1)) ? '0 : slot + 1'b1;
        if (!full) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.mul_start) begin
        iter <= IW'(CW);
      end else if (cmd.sqrt_start || cmd.div_start) begin
        iter <= IW'(RW);
      end else if (cmd.mul_step || cmd.sqrt_step || cmd.div_step) begin
        iter <= iter - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_q <= sample_in;
    end
    if (cmd.fetch) begin
      old_q  <= ram_rdata;
      sq_new <= sq_new_full[2*swsd_pkg::SAMPLE_W-2:0];
      sq_old <= sq_old_full[2*swsd_pkg::SAMPLE_W-2:0];
    end

    // n * S2 by shift and add; S1 squared on the side
    if (cmd.mul_start) begin
      acc    <= '0;
      mcand  <= PW'(sqsum);
      mplier <= count;
      mag    <= sum_abs[MAGW-1:0];
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      mag_sq <= PW'(mag * mag);
    end

    // one root bit per step
    if (cmd.sqrt_start) begin
      rad  <= (acc > mag_sq) ? (2*RW)'(acc - mag_sq) : '0;
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end

    // restoring divide of the root by n, quotient shifts into dvd
    if (cmd.div_start) begin
      dvd  <= root;
      drem <= '0;
    end else if (cmd.div_step) begin
      if (dtrial >= {1'b0, count}) begin
        drem <= dtrial - {1'b0, count};
        dvd  <= {dvd[RW-2:0], 1'b1};
      end else begin
        drem <= dtrial;
        dvd  <= {dvd[RW-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      deviation    <= status.ge2 ? dvd[swsd_pkg::DEV_W-1:0] : '0;
      samples_held <= swsd_pkg::HELD_W'(count);
    end
  end

  assign status.ge2       = (count >= CW'(2));
  assign status.iter_done = (iter == '0);

endmodule

[dv/tb_sliding_window_std_dev.sv]
// Self-checking bench for sliding_window_std_dev: directed table, then random segments.
// Holds its own window predictor (ring, sum, sum of squares, integer root).
// Depends on swsd_pkg and the RTL top only.
module tb_sliding_window_std_dev;

  localparam int WINDOW      = 50;
  localparam int N_RANDOM    = 1030;
  localparam int SEG_LEN     = 70;
  localparam int LONG_HOLD   = 600;
  localparam int HOLD_AT     = 300;
  localparam int DRAIN_AT    = 700;
  localparam int TAIL        = 200;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [swsd_pkg::DEV_W-1:0]  deviation;
    logic [swsd_pkg::HELD_W-1:0] held;
  } stat_t;

  typedef struct packed {
    logic [swsd_pkg::SAMPLE_W-1:0] smp;
    logic                          typed;
    logic [swsd_pkg::DEV_W-1:0]    deviation;
    logic [swsd_pkg::HELD_W-1:0]   held;
  } dir_row_t;

  typedef enum int {STY_FULL, STY_LEVEL, STY_CONST, STY_SWING, STY_EXTREMES} style_t;

  localparam int N_DIRECTED = 20;
  // typed rows: one sample after reset, then the widest possible pair
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{16'h7fff, 1'b1, 16'd0,     6'd1},
    '{16'h8000, 1'b1, 16'd32767, 6'd2},
    '{16'h8000, 1'b0, 16'd0, 6'd0},
    '{16'h0000, 1'b0, 16'd0, 6'd0},
    '{16'hffff, 1'b0, 16'd0, 6'd0},
    '{16'h0001, 1'b0, 16'd0, 6'd0},
    '{16'h5555, 1'b0, 16'd0, 6'd0},
    '{16'haaaa, 1'b0, 16'd0, 6'd0},
    '{16'h7fff, 1'b0, 16'd0, 6'd0},
    '{16'h8000, 1'b0, 16'd0, 6'd0},
    '{16'h7fff, 1'b0, 16'd0, 6'd0},
    '{16'h8000, 1'b0, 16'd0, 6'd0},
    '{16'h0000, 1'b0, 16'd0, 6'd0},
    '{16'h0000, 1'b0, 16'd0, 6'd0},
    '{16'h00ff, 1'b0, 16'd0, 6'd0},
    '{16'hff00, 1'b0, 16'd0, 6'd0},
    '{16'h4000, 1'b0, 16'd0, 6'd0},
    '{16'hc000, 1'b0, 16'd0, 6'd0},
    '{16'h8001, 1'b0, 16'd0, 6'd0},
    '{16'h7ffe, 1'b0, 16'd0, 6'd0}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [swsd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [swsd_pkg::OUT_TDATA_W-1:0] m_tdata;

  sliding_window_std_dev #(.WINDOW(WINDOW)) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  // predictor state
  longint      win_ring [WINDOW];
  int unsigned win_slot;
  int unsigned win_count;
  longint      win_sum;
  longint      win_sq;

  stat_t       pending_stats [$];
  int unsigned words_in;
  int unsigned words_out;
  int unsigned mismatches;
  int unsigned full_words;
  int unsigned cycle_count;

  // random shaping state
  style_t      seg_style;
  int          seg_level;
  int          seg_spread;
  logic [15:0] seg_const;
  bit          swing_phase;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               pending_stats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // moves the window on by one sample and returns the deviation word it gives
  function automatic stat_t advance_window(input logic [swsd_pkg::SAMPLE_W-1:0] raw);
    longint          x;
    longint          old;
    longint unsigned n;
    longint unsigned mag;
    longint unsigned a;
    longint unsigned b;
    longint unsigned spread;
    stat_t           r;
    x = longint'($signed(raw));
    if (win_slot >= WINDOW) win_slot = 0;
    if (win_count >= WINDOW) begin
      old       = win_ring[win_slot];
      win_sum   = win_sum - old;
      win_sq    = win_sq - old * old;
      win_count = WINDOW;
      full_words++;
    end else begin
      win_count++;
    end
    win_ring[win_slot] = x;
    win_sum  = win_sum + x;
    win_sq   = win_sq + x * x;
    win_slot = (win_slot + 1 >= WINDOW) ? 0 : win_slot + 1;
    r.deviation = '0;
    if (win_count >= 2) begin
      n      = win_count;
      mag    = (win_sum < 0) ? -win_sum : win_sum;
      a      = n * longint'(win_sq);
      b      = mag * mag;
      spread = (a > b) ? a - b : 0;
      r.deviation = swsd_pkg::DEV_W'(floor_root(spread) / n);
    end
    r.held = swsd_pkg::HELD_W'(win_count);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned idx,
                               input longint unsigned got, input longint unsigned want);
    $display("word %0d: %s got %0d, want %0d", idx, field, got, want);
    mismatches++;
  endtask

  function automatic int draw_gap(input bit busy);
    return busy ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic logic [15:0] pick_sample();
    int v;
    case (seg_style)
      STY_FULL:  return 16'($urandom_range(0, 65535));
      STY_LEVEL: begin
        v = seg_level + $urandom_range(0, 2 * seg_spread) - seg_spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
      end
      STY_CONST: return ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                     : seg_const;
      STY_SWING: begin
        swing_phase = ~swing_phase;
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
        return swing_phase ? 16'h7fff : 16'h8000;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          4: return 16'h0001;
          default: return 16'h8001;
        endcase
      end
    endcase
  endfunction

  function automatic void new_segment();
    int spreads [3] = '{1, 16, 1024};
    seg_style  = style_t'($urandom_range(0, 4));
    seg_level  = $urandom_range(0, 65535) - 32768;
    seg_spread = spreads[$urandom_range(0, 2)];
    seg_const  = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535))
               : (($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7fff);
  endfunction

  // offers one word; s_tvalid stays high when the next word follows at once
  task automatic offer_sample(input logic [swsd_pkg::SAMPLE_W-1:0] smp, input bit typed,
                              input stat_t typed_res, input bit busy);
    int    gap;
    stat_t r;
    stat_t due;
    gap = draw_gap(busy);
    if (gap > 0 || words_in == DRAIN_AT) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (words_in == DRAIN_AT) begin
        do @(posedge clk); while (pending_stats.size() != 0);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    r = advance_window(smp);
    due = typed ? typed_res : r;
    pending_stats = {pending_stats, due};
    words_in++;
  endtask

  initial begin
    bit    tx_busy;
    stat_t typed_res;
    win_ring    = '{default: 0};
    win_slot    = 0;
    win_count   = 0;
    win_sum     = 0;
    win_sq      = 0;
    words_in    = 0;
    words_out   = 0;
    mismatches  = 0;
    full_words  = 0;
    cycle_count = 0;
    swing_phase = 1'b0;
    new_segment();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    fork
      begin : drain
        bit    rx_busy;
        int    gap;
        stat_t want;
        rx_busy = 1'b1;
        forever begin
          if (words_out % 40 == 0) rx_busy = ($urandom_range(0, 2) != 0);
          gap = (words_out == HOLD_AT) ? LONG_HOLD : draw_gap(rx_busy);
          if (gap > 0) begin
            m_tready <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          m_tready <= 1'b1;
          do @(posedge clk); while (!m_tvalid);
          if (pending_stats.size() == 0) begin
            note_mismatch("unexpected word", words_out, m_tdata, 0);
          end else begin
            want = pending_stats.pop_front();
            if (m_tdata[swsd_pkg::DEV_W-1:0] !== want.deviation)
              note_mismatch("deviation", words_out, m_tdata[swsd_pkg::DEV_W-1:0],
                            want.deviation);
            if (m_tdata[swsd_pkg::DEV_W +: swsd_pkg::HELD_W] !== want.held)
              note_mismatch("samples_held", words_out,
                            m_tdata[swsd_pkg::DEV_W +: swsd_pkg::HELD_W], want.held);
          end
          words_out++;
        end
      end
    join_none

    @(posedge clk);
    tx_busy = 1'b1;
    foreach (dir_rows[i]) begin
      typed_res.deviation = dir_rows[i].deviation;
      typed_res.held      = dir_rows[i].held;
      offer_sample(dir_rows[i].smp, dir_rows[i].typed, typed_res, tx_busy);
    end

    typed_res = '0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % SEG_LEN == 0) new_segment();
      if (k % 40 == 0) tx_busy = ($urandom_range(0, 2) != 0);
      offer_sample(pick_sample(), 1'b0, typed_res, tx_busy);
    end
    s_tvalid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (pending_stats.size() != 0)
      note_mismatch("words never returned", words_out, 0, pending_stats.size());

    $display("%0d samples in, %0d deviation words out, %0d of them with the window full",
             words_in, words_out, full_words);
    $display("covered fill from reset, ring wrap-round, output back-pressure and input drain");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
